// File: hw/rtl/stpt_pkg.sv
// Shared types and constants for the strided tensor partial trace block.
// Used by the top level and the checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stpt_pkg;

	localparam int MAX_RANK    = 6;
	localparam int STORE_DEPTH = 4096;
	localparam int ELEM_BITS   = 32;

	localparam int AXIS_W    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int ADDR_W    = $clog2(STORE_DEPTH);
	localparam int SIZE_W    = 13;
	localparam int STRIDE_W  = 12;
	localparam int DSTRIDE_W = STRIDE_W + 1;
	localparam int IDX_W     = 12;
	localparam int CONTRIB_W = SIZE_W + STRIDE_W;
	localparam int PROD_W    = SIZE_W + DSTRIDE_W;
	localparam int OFFS_W    = CONTRIB_W + $clog2(MAX_RANK) + 1;
	localparam int TOP_W     = ((OFFS_W > PROD_W) ? OFFS_W : PROD_W) + 1;

	localparam logic [1:0] OP_AXIS = 2'd0;
	localparam logic [1:0] OP_ELEM = 2'd1;
	localparam logic [1:0] OP_EMIT = 2'd2;

	localparam logic [1:0] FLAG_OK    = 2'd0;
	localparam logic [1:0] FLAG_EMPTY = 2'd1;
	localparam logic [1:0] FLAG_BAD   = 2'd2;

	localparam logic [1:0] REG_FIRST  = 2'd0;
	localparam logic [1:0] REG_SECOND = 2'd1;
	localparam logic [1:0] REG_RANK   = 2'd2;

	typedef logic [ELEM_BITS-1:0] elem_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TOP,
		ST_SUM,
		ST_RESULT,
		ST_ADVANCE
	} state_t;

endpackage

`default_nettype wire

// File: hw/rtl/stpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module stpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/strided_tensor_partial_trace.sv
// Top level: partial trace of a strided integer tensor over two axes.
// Depends on stpt_pkg and stpt_ram.
//
//   channel | signals                                  | handshake
//   --------+------------------------------------------+----------------------
//   in      | op, axis_number, axis_size, axis_stride, | in_valid / in_ready
//           | element_addr, element_value              |
//   out     | sum_value, out_index, last, flag         | out_valid / out_ready
//   cfg     | cfg_index, cfg_data                      | cfg_we, no wait
//
// Axis and element loads are taken while idle. An emit passes through the check,
// bound test and summing (one store read per cycle from the single read port of
// the element RAM), and after the result steps the
// odometer one axis per cycle. A result waits in the output register while the
// next item is taken; a further emit then holds until that slot frees. No
// clearing pass: the element store is undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module strided_tensor_partial_trace (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [1:0]                            op,
	input  wire logic [2:0]                            axis_number,
	input  wire logic [stpt_pkg::SIZE_W-1:0]           axis_size,
	input  wire logic [stpt_pkg::STRIDE_W-1:0]         axis_stride,
	input  wire logic [11:0]                           element_addr,
	input  wire logic signed [31:0]                    element_value,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [31:0]                         sum_value,
	output logic      [stpt_pkg::IDX_W-1:0]            out_index,
	output logic                                       last,
	output logic      [1:0]                            flag,
	input  wire logic                                  cfg_we,
	input  wire logic [1:0]                            cfg_index,
	input  wire logic [2:0]                            cfg_data
);

	import stpt_pkg::*;

	state_t state_q, state_d;

	logic [2:0] first_q, second_q, rank_q;

	logic [SIZE_W-1:0]    size_q    [MAX_RANK];
	logic [STRIDE_W-1:0]  stride_q  [MAX_RANK];
	logic [SIZE_W-1:0]    digit_q   [MAX_RANK];
	logic [CONTRIB_W-1:0] contrib_q [MAX_RANK];
	logic [OFFS_W-1:0]    start_q;
	logic [IDX_W-1:0]     counter_q;

	// per-item working registers
	logic [SIZE_W-1:0]    len_q;
	logic [DSTRIDE_W-1:0] dstride_q;
	logic [PROD_W-1:0]    prod_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [SIZE_W-1:0]    cnt_q;
	logic                 pend_q;
	elem_t                acc_q;
	logic [1:0]           res_flag_q;
	logic                 res_last_q;
	logic                 adv_q;
	logic [AXIS_W-1:0]    ax_q;

	logic signed [31:0]   sum_value_q;
	logic [IDX_W-1:0]     out_index_q;
	logic                 last_q;
	logic [1:0]           flag_q;
	logic                 out_valid_q;

	// decode of the current configuration and odometer
	logic [MAX_RANK-1:0]  survivor;
	logic [MAX_RANK-1:0]  at_max;
	logic [SIZE_W-1:0]    size_first, size_second;
	logic [STRIDE_W-1:0]  stride_first, stride_second;
	logic                 bad_axes, empty_out, last_pos;
	logic [TOP_W-1:0]     top;

	logic in_acc, restart, out_free, issue, elem_we;
	elem_t rdata;

	always_comb begin
		for (int i = 0; i < MAX_RANK; i++) begin
			survivor[i] = (3'(i) < rank_q) && (3'(i) != first_q) && (3'(i) != second_q);
			at_max[i]   = !(({1'b0, digit_q[i]} + (SIZE_W+1)'(1)) < {1'b0, size_q[i]});
		end
		size_first    = '0;
		size_second   = '0;
		stride_first  = '0;
		stride_second = '0;
		if (32'(first_q) < MAX_RANK) begin
			size_first   = size_q[first_q[AXIS_W-1:0]];
			stride_first = stride_q[first_q[AXIS_W-1:0]];
		end
		if (32'(second_q) < MAX_RANK) begin
			size_second   = size_q[second_q[AXIS_W-1:0]];
			stride_second = stride_q[second_q[AXIS_W-1:0]];
		end
		bad_axes = (first_q == second_q) || (first_q >= rank_q) || (second_q >= rank_q)
			|| (rank_q < 3'd2) || (32'(rank_q) > MAX_RANK) || (size_first != size_second);
		empty_out = 1'b0;
		last_pos  = 1'b1;
		for (int i = 0; i < MAX_RANK; i++) begin
			if (survivor[i] && size_q[i] == '0) empty_out = 1'b1;
			if (survivor[i] && !at_max[i]) last_pos = 1'b0;
		end
		top = TOP_W'(start_q) + TOP_W'(prod_q);
	end

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign restart  = (cfg_we && cfg_index <= REG_RANK) || (in_acc && op == OP_AXIS);
	assign elem_we  = in_acc && op == OP_ELEM && 32'(element_addr) < STORE_DEPTH;
	assign issue    = (state_q == ST_SUM) && (cnt_q != len_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && op == OP_EMIT) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = (bad_axes || empty_out) ? ST_RESULT : ST_TOP;
			end
			ST_TOP: begin
				if (len_q == '0 || 32'(top) >= STORE_DEPTH) state_d = ST_RESULT;
				else state_d = ST_SUM;
			end
			ST_SUM: begin
				if (cnt_q == len_q && !pend_q) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) state_d = adv_q ? ST_ADVANCE : ST_IDLE;
			end
			ST_ADVANCE: begin
				if ((survivor[ax_q] && !at_max[ax_q]) || ax_q == '0) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration, tables and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= 3'd0;
			second_q  <= 3'd1;
			rank_q    <= 3'd2;
			start_q   <= '0;
			counter_q <= '0;
			for (int i = 0; i < MAX_RANK; i++) begin
				size_q[i]    <= '0;
				stride_q[i]  <= '0;
				digit_q[i]   <= '0;
				contrib_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FIRST:  first_q  <= cfg_data;
					REG_SECOND: second_q <= cfg_data;
					REG_RANK:   rank_q   <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc && op == OP_AXIS && 32'(axis_number) < MAX_RANK) begin
				size_q[axis_number[AXIS_W-1:0]]   <= axis_size;
				stride_q[axis_number[AXIS_W-1:0]] <= axis_stride;
			end
			if (restart) begin
				start_q   <= '0;
				counter_q <= '0;
				for (int i = 0; i < MAX_RANK; i++) begin
					digit_q[i]   <= '0;
					contrib_q[i] <= '0;
				end
			end
			if (state_q == ST_RESULT && out_free && adv_q) begin
				counter_q <= res_last_q ? '0 : counter_q + IDX_W'(1);
			end
			if (state_q == ST_ADVANCE && survivor[ax_q]) begin
				if (!at_max[ax_q]) begin
					digit_q[ax_q]   <= digit_q[ax_q] + SIZE_W'(1);
					contrib_q[ax_q] <= contrib_q[ax_q] + CONTRIB_W'(stride_q[ax_q]);
					start_q         <= start_q + OFFS_W'(stride_q[ax_q]);
				end else begin
					// wrap this digit and take back its share of the offset
					digit_q[ax_q]   <= '0;
					contrib_q[ax_q] <= '0;
					start_q         <= start_q - OFFS_W'(contrib_q[ax_q]);
				end
			end
		end
	end

	// per-item datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			adv_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_CHECK: adv_q  <= !(bad_axes || empty_out);
				ST_SUM:   pend_q <= issue;
				default:  pend_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ax_q <= AXIS_W'(MAX_RANK - 1);
			end
			ST_CHECK: begin
				len_q      <= size_first;
				dstride_q  <= DSTRIDE_W'(stride_first) + DSTRIDE_W'(stride_second);
				prod_q     <= PROD_W'(size_first - SIZE_W'(1))
					* PROD_W'(DSTRIDE_W'(stride_first) + DSTRIDE_W'(stride_second));
				acc_q      <= '0;
				res_last_q <= (bad_axes || empty_out) ? 1'b1 : last_pos;
				res_flag_q <= bad_axes ? FLAG_BAD : (empty_out ? FLAG_EMPTY : FLAG_OK);
			end
			ST_TOP: begin
				addr_q <= start_q[ADDR_W-1:0];
				cnt_q  <= '0;
				if (len_q != '0 && 32'(top) >= STORE_DEPTH) res_flag_q <= FLAG_BAD;
			end
			ST_SUM: begin
				if (issue) begin
					addr_q <= addr_q + ADDR_W'(dstride_q);
					cnt_q  <= cnt_q + SIZE_W'(1);
				end
				if (pend_q) acc_q <= acc_q + rdata;
			end
			ST_ADVANCE: begin
				ax_q <= ax_q - AXIS_W'(1);
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			sum_value_q <= (res_flag_q == FLAG_OK) ? 32'(acc_q) : '0;
			out_index_q <= adv_q ? counter_q : '0;
			last_q      <= res_last_q;
			flag_q      <= res_flag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign sum_value = sum_value_q;
	assign out_index = out_index_q;
	assign last      = last_q;
	assign flag      = flag_q;

	stpt_ram #(
		.WIDTH (ELEM_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (elem_we),
		.waddr (ADDR_W'(element_addr)),
		.wdata (ELEM_BITS'(element_value)),
		.raddr (addr_q),
		.rdata (rdata)
	);

endmodule

`default_nettype wire

// File: hw/rtl/stpt_checker.sv
// Port-level checks on the strided tensor partial trace block, bound to the top.
// Depends on stpt_pkg and strided_tensor_partial_trace.
`timescale 1ns / 1ps
`default_nettype none

module stpt_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic [1:0]                    op,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic signed [31:0]            sum_value,
	input wire logic [stpt_pkg::IDX_W-1:0]    out_index,
	input wire logic                          last,
	input wire logic [1:0]                    flag
);

	import stpt_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sum_value) && $stable(flag))
		else $error("result changed while stalled");

	a_flag_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flag != FLAG_OK |-> sum_value == 32'sd0)
		else $error("flagged result carries a sum");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flag == FLAG_EMPTY |-> last && out_index == '0)
		else $error("empty output result not final at index zero");

	a_flag_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> flag == FLAG_OK || flag == FLAG_EMPTY || flag == FLAG_BAD)
		else $error("unknown flag code");

	// an emit keeps the block busy for at least the next cycle
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_EMIT |=> !in_ready)
		else $error("item taken straight after an emit");

endmodule

bind strided_tensor_partial_trace stpt_checker u_stpt_checker (.*);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for strided_tensor_partial_trace: directed corner cases, then random
// tensor walks, each trace result checked against a predictor kept inside the bench.
// Depends on stpt_pkg and the block's RTL.

module tb;
	import stpt_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;	// unused op, must be ignored
	localparam int ITEM_TARGET   = 1550;
	localparam int SETTLE_CYCLES = 2 * MAX_RANK + 8;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		logic [31:0] total;
		logic [11:0] idx;
		logic        last;
		logic [1:0]  flag;
	} trace_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          op;
	logic [2:0]          axis_number;
	logic [SIZE_W-1:0]   axis_size;
	logic [STRIDE_W-1:0] axis_stride;
	logic [11:0]         element_addr;
	logic signed [31:0]  element_value;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic signed [31:0]  sum_value;
	logic [IDX_W-1:0]    out_index;
	logic                last;
	logic [1:0]          flag;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [2:0]          cfg_data;

	strided_tensor_partial_trace dut (.*);

	// predictor state
	logic [2:0]          cfg_first, cfg_second, cfg_rank;
	logic [SIZE_W-1:0]   axis_len [MAX_RANK];
	logic [STRIDE_W-1:0] axis_step [MAX_RANK];
	logic [31:0]         mem_model [STORE_DEPTH];
	bit                  mem_set [STORE_DEPTH];
	int                  digit [MAX_RANK];
	longint              walk_base;
	logic [11:0]         walk_count;

	trace_t trace_q[$];
	trace_t head_trace;

	bit steady = 1'b0;
	int cycle_count = 0;
	int faults = 0;
	int items_sent = 0;
	int fills = 0;
	int cfg_writes = 0;
	int results_checked = 0;
	int random_phases = 0;
	int flags_seen [3] = '{0, 0, 0};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void restart_walk();
		for (int a = 0; a < MAX_RANK; a++)
			digit[a] = 0;
		walk_base = 0;
		walk_count = '0;
	endfunction

	function automatic void model_reset();
		cfg_first = 3'd0;
		cfg_second = 3'd1;
		cfg_rank = 3'd2;
		for (int a = 0; a < MAX_RANK; a++) begin
			axis_len[a] = '0;
			axis_step[a] = '0;
		end
		for (int a = 0; a < STORE_DEPTH; a++)
			mem_set[a] = 1'b0;
		restart_walk();
	endfunction

	function automatic bit kept_axis(int ax);
		return ax < cfg_rank && ax != cfg_first && ax != cfg_second;
	endfunction

	function automatic logic [1:0] trace_status();
		if (cfg_first == cfg_second || cfg_rank < 2 || cfg_rank > MAX_RANK ||
				cfg_first >= cfg_rank || cfg_second >= cfg_rank ||
				axis_len[cfg_first] != axis_len[cfg_second])
			return FLAG_BAD;
		for (int a = 0; a < MAX_RANK; a++)
			if (kept_axis(a) && axis_len[a] == 0)
				return FLAG_EMPTY;
		return FLAG_OK;
	endfunction

	// Diagonal from the current start offset; true when it is non-empty and fits the store.
	function automatic bit diag_in_store(output longint step, output int len);
		len = axis_len[cfg_first];
		step = longint'(axis_step[cfg_first]) + longint'(axis_step[cfg_second]);
		return len > 0 && walk_base + longint'(len - 1) * step < STORE_DEPTH;
	endfunction

	function automatic trace_t predict_trace();
		trace_t r;
		bit at_end, carry;
		longint step, addr;
		int len;
		r.total = '0;
		r.idx = '0;
		r.last = 1'b1;
		r.flag = trace_status();
		if (r.flag != FLAG_OK)
			return r;
		at_end = 1'b1;
		for (int a = 0; a < MAX_RANK; a++)
			if (kept_axis(a) && digit[a] + 1 < axis_len[a])
				at_end = 1'b0;
		if (diag_in_store(step, len)) begin
			addr = walk_base;
			repeat (len) begin
				r.total = r.total + mem_model[addr];
				addr += step;
			end
		end else if (len > 0) begin
			r.flag = FLAG_BAD;
		end
		r.idx = walk_count;
		r.last = at_end;
		// step the odometer, last surviving axis fastest
		carry = 1'b1;
		for (int a = MAX_RANK - 1; a >= 0; a--) begin
			if (carry && kept_axis(a)) begin
				if (digit[a] + 1 < axis_len[a]) begin
					digit[a]++;
					walk_base += axis_step[a];
					carry = 1'b0;
				end else begin
					walk_base -= longint'(digit[a]) * longint'(axis_step[a]);
					digit[a] = 0;
				end
			end
		end
		walk_count = at_end ? 12'd0 : walk_count + 12'd1;
		return r;
	endfunction

	function automatic int pick_elem();
		int r;
		r = $urandom_range(99, 0);
		if (r < 10)
			return 32'h8000_0000;
		if (r < 20)
			return 32'h7fff_ffff;
		if (r < 25)
			return -1;
		if (r < 30)
			return 0;
		return $urandom;
	endfunction

	// Drive one item and hold it until accepted, then update the predictor.
	task automatic push_item(input int o, input int ax, input int sz, input int st,
			input int addr, input int val);
		trace_t r;
		@(negedge clk);
		if (!steady && $urandom_range(99, 0) < 15) begin
			in_valid = 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		op = o[1:0];
		axis_number = ax[2:0];
		axis_size = sz[SIZE_W-1:0];
		axis_stride = st[STRIDE_W-1:0];
		element_addr = addr[11:0];
		element_value = val;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (op != OP_SPARE)
			items_sent++;
		case (op)
			OP_AXIS: begin
				if (axis_number < MAX_RANK) begin
					axis_len[axis_number] = axis_size;
					axis_step[axis_number] = axis_stride;
				end
				restart_walk();
			end
			OP_ELEM: begin
				mem_model[element_addr] = element_value;
				mem_set[element_addr] = 1'b1;
			end
			OP_EMIT: begin
				r = predict_trace();
				flags_seen[r.flag]++;
				trace_q = {trace_q, r};
			end
			default: ;
		endcase
	endtask

	task automatic load_axis(input int ax, input int sz, input int st);
		push_item(OP_AXIS, ax, sz, st, $urandom, $urandom);
	endtask

	task automatic load_elem(input int addr, input int val);
		push_item(OP_ELEM, $urandom, $urandom, $urandom, addr, val);
	endtask

	task automatic spare_item();
		push_item(OP_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Write every store entry the coming diagonal reads that has not been written yet.
	task automatic fill_diag();
		longint step, addr;
		int len;
		if (trace_status() == FLAG_OK && diag_in_store(step, len)) begin
			addr = walk_base;
			repeat (len) begin
				if (!mem_set[addr]) begin
					fills++;
					load_elem(int'(addr), pick_elem());
				end
				addr += step;
			end
		end
	endtask

	task automatic emit_trace();
		fill_diag();
		push_item(OP_EMIT, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Hold the sender until every trace is back and loads have settled.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (trace_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [2:0] val);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_FIRST:  cfg_first = val;
			REG_SECOND: cfg_second = val;
			REG_RANK:   cfg_rank = val;
			default: ;
		endcase
		restart_walk();
		cfg_writes++;
	endtask

	task automatic log_fault(input string what, input trace_t want);
		faults++;
		if (faults <= 10)
			$display({"cycle %0d %s: expected sum %0d idx %0d last %0b flag %0d,",
				" got sum %0d idx %0d last %0b flag %0d"},
				cycle_count, what, $signed(want.total), want.idx, want.last, want.flag,
				sum_value, out_index, last, flag);
	endtask

	always @(negedge clk)
		out_ready <= steady || ($urandom_range(99, 0) >= 15);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (trace_q.size() == 0) begin
				log_fault("result with nothing pending", '0);
			end else begin
				head_trace = trace_q.pop_front();
				results_checked++;
				if (sum_value !== head_trace.total || out_index !== head_trace.idx ||
						last !== head_trace.last || flag !== head_trace.flag)
					log_fault("field mismatch", head_trace);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout at cycle %0d with %0d traces pending", cycle_count,
				trace_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Reset state: empty diagonal on rank 2 sums to zero; op 3 is ignored.
	task automatic test_reset_state();
		emit_trace();
		spare_item();
	endtask

	// Rank 2 has no surviving axes: every trace is index 0 and last.
	task automatic test_scalar_trace();
		load_axis(0, 3, 1);
		load_axis(1, 3, 64);
		emit_trace();
		emit_trace();
	endtask

	// Diagonal of length 4096 with zero stride: one entry summed 4096 times, wrapping.
	task automatic test_long_diagonal();
		load_axis(0, 4096, 0);
		load_axis(1, 4096, 0);
		emit_trace();
	endtask

	// Diagonal top exactly at the last entry, then one past the end of the store.
	task automatic test_offset_out_of_store();
		load_axis(0, 2, 4095);
		load_axis(1, 2, 0);
		emit_trace();
		load_axis(1, 2, 1);
		emit_trace();
	endtask

	// Surviving axis of size zero gives the empty-output flag.
	task automatic test_empty_output();
		set_reg(REG_RANK, 3'd3);
		emit_trace();
	endtask

	task automatic test_bad_axes();
		set_reg(REG_FIRST, 3'd1);
		emit_trace();
		set_reg(REG_FIRST, 3'd0);
		set_reg(REG_SECOND, 3'd3);
		emit_trace();
		set_reg(REG_SECOND, 3'd1);
		load_axis(1, 3, 1);
		emit_trace();
	endtask

	// Two surviving axes of size 2: four positions, then back to index 0.
	task automatic test_full_walk();
		set_reg(REG_RANK, 3'd4);
		set_reg(REG_FIRST, 3'd3);
		set_reg(REG_SECOND, 3'd1);
		load_axis(3, 2, 5);
		load_axis(1, 2, 9);
		load_axis(0, 2, 100);
		load_axis(2, 2, 20);
		repeat (5) emit_trace();
	endtask

	task automatic test_random_walks();
		int rk, fa, sa, d, ts1, ts2, r, ax;
		while (items_sent < ITEM_TARGET) begin
			steady = (random_phases == 2);
			if (random_phases == 0) begin
				rk = 6; fa = 5; sa = 4;
			end else if (random_phases == 1) begin
				rk = 2; fa = 1; sa = 0;
			end else begin
				rk = $urandom_range(6, 2);
				if ($urandom_range(99, 0) < 88) begin
					fa = $urandom_range(rk - 1, 0);
					sa = (fa + $urandom_range(rk - 1, 1)) % rk;
				end else begin
					fa = $urandom_range(5, 0);
					sa = $urandom_range(5, 0);
				end
			end
			set_reg(REG_RANK, rk[2:0]);
			set_reg(REG_FIRST, fa[2:0]);
			set_reg(REG_SECOND, sa[2:0]);

			r = $urandom_range(99, 0);
			d = (r < 6) ? 0 : (r < 94) ? $urandom_range(6, 1) : $urandom_range(64, 16);
			ts1 = (d >= 16) ? $urandom_range(3, 0) :
				($urandom_range(99, 0) < 5) ? 4095 : $urandom_range(40, 0);
			ts2 = (d >= 16) ? $urandom_range(3, 0) : $urandom_range(40, 0);
			for (int a = 0; a < MAX_RANK; a++) begin
				if (a == fa)
					load_axis(a, d, ts1);
				else if (a == sa)
					load_axis(a, d, ts2);
				else if (a < rk)
					load_axis(a, ($urandom_range(99, 0) < 5) ? 0 : $urandom_range(3, 1),
						($urandom_range(99, 0) < 4) ? 4095 : $urandom_range(300, 0));
				else
					load_axis(a, $urandom_range(4096, 0), $urandom_range(4095, 0));
			end

			// mostly traces along the walk, with loads and restarts mixed in
			repeat ($urandom_range(150, 60)) begin
				r = $urandom_range(99, 0);
				ax = $urandom_range(5, 0);
				if (r < 74)
					emit_trace();
				else if (r < 84)
					load_elem($urandom_range(4095, 0), pick_elem());
				else if (r < 89)
					spare_item();
				else if (r < 94)
					load_axis(ax, axis_len[ax], axis_step[ax]);
				else if (r < 97)
					load_axis(ax, $urandom_range(4, 0), $urandom_range(40, 0));
				else
					load_axis($urandom_range(7, 6), $urandom_range(4096, 0), $urandom);
			end
			random_phases++;
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_AXIS;
		axis_number = '0;
		axis_size = '0;
		axis_stride = '0;
		element_addr = '0;
		element_value = '0;
		cfg_we = 1'b0;
		cfg_index = REG_FIRST;
		cfg_data = '0;
		model_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_scalar_trace();
		test_long_diagonal();
		test_offset_out_of_store();
		test_empty_output();
		test_bad_axes();
		test_full_walk();
		test_random_walks();
		drain();

		$display("Sent %0d items (%0d diagonal fills) across %0d register writes",
			items_sent, fills, cfg_writes);
		$display("and %0d random phases; checked %0d traces: %0d normal, %0d empty,",
			random_phases, results_checked, flags_seen[FLAG_OK], flags_seen[FLAG_EMPTY]);
		$display("%0d bad axes or offset; %0d faults.", flags_seen[FLAG_BAD], faults);
		if (faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
